>>> sv/bounded_sorted_list_core_assert.svh
// Assertion macros for the bounded sorted list core
`ifndef BOUNDED_SORTED_LIST_CORE_ASSERT_SVH
`define BOUNDED_SORTED_LIST_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BSL_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BSL_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BSL_ASSERT_CLK(label, prop, msg)
`define BSL_ASSERT_RST(label, prop, msg)
`endif

`endif

>>> sv/bsl_pkg.sv
// Types and constants shared by the bounded sorted list core
`default_nettype none
package bsl_pkg;
    localparam int DEPTH = 16;
    localparam int KEY_W = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = 4;

    typedef enum logic [1:0] {
        K_APPEND = 2'd0,
        K_INSERT = 2'd1,
        K_REMOVE = 2'd2,
        K_READ   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    // broadcast to every cell
    typedef struct packed {
        t_kind                    kind;
        logic signed [KEY_W-1:0]  key;
        logic [POS_W-1:0]         position;
        logic [CNT_W-1:0]         count;
        logic                     wr_en;
    } t_cmd;

    // passed from cell to cell, head to tail
    typedef struct packed {
        logic                     found;
        logic [KEY_W-1:0]         rd;
    } t_link;
endpackage
`default_nettype wire

>>> sv/bsl_if.sv
// Valid/ready channel interfaces for commands and results
`default_nettype none
interface bsl_cmd_if;
    logic                valid;
    logic                ready;
    logic [1:0]          kind;
    logic signed [31:0]  key;
    logic [3:0]          position;

    modport source (output valid, kind, key, position, input ready);
    modport sink (input valid, kind, key, position, output ready);
endinterface

interface bsl_res_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  read_key;
    logic [4:0]          entry_count;
    logic [1:0]          status;

    modport source (output valid, read_key, entry_count, status, input ready);
    modport sink (input valid, read_key, entry_count, status, output ready);
endinterface
`default_nettype wire

>>> sv/bsl_cell.sv
// One list slot: holds a key, finds its role in the step, shifts with its neighbors
`default_nettype none
module bsl_cell (
    input  wire logic                            i_clk,
    input  wire logic [bsl_pkg::IDX_W-1:0]       i_idx,
    input  wire bsl_pkg::t_cmd                   i_cmd,
    input  wire logic signed [bsl_pkg::KEY_W-1:0] i_left_key,
    input  wire logic signed [bsl_pkg::KEY_W-1:0] i_right_key,
    input  wire bsl_pkg::t_link                  i_link,
    output logic signed [bsl_pkg::KEY_W-1:0]     o_key,
    output bsl_pkg::t_link                       o_link
);
    logic signed [bsl_pkg::KEY_W-1:0] r_key;
    logic signed [bsl_pkg::KEY_W-1:0] n_key;
    logic                             occ;
    logic                             hit;

    assign occ = {1'b0, i_idx} < i_cmd.count;

    always_comb begin
        unique case (i_cmd.kind)
            bsl_pkg::K_APPEND: hit = !occ;
            // first slot not below the key, or the first free one
            bsl_pkg::K_INSERT: hit = !occ || !(r_key < i_cmd.key);
            bsl_pkg::K_REMOVE: hit = occ && (r_key == i_cmd.key);
            bsl_pkg::K_READ:   hit = occ &&
                                     (bsl_pkg::POS_W'(i_idx) == i_cmd.position);
            default:           hit = 1'b0;
        endcase
    end

    always_comb begin
        o_link.found = i_link.found | hit;
        o_link.rd    = i_link.rd;
        if (i_cmd.kind == bsl_pkg::K_READ && hit) begin
            o_link.rd = i_link.rd | r_key;
        end
    end

    always_comb begin
        n_key = r_key;
        if (i_cmd.wr_en) begin
            case (i_cmd.kind)
                bsl_pkg::K_APPEND, bsl_pkg::K_INSERT: begin
                    if (i_link.found) begin
                        n_key = i_left_key;
                    end else if (hit) begin
                        n_key = i_cmd.key;
                    end
                end
                bsl_pkg::K_REMOVE: begin
                    if (i_link.found || hit) begin
                        n_key = i_right_key;
                    end
                end
                default: n_key = r_key;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;
endmodule
`default_nettype wire

>>> sv/bounded_sorted_list_core.sv
// Bounded sorted list core: append, sorted insert, remove first equal, indexed read.
// The result beat of an accepted command is registered at the edge that accepts it.
// One command per cycle while the result side is not stalled; slots from the hit one on shift as it is accepted.
// A stalled result holds the command side only until the output register frees.
// Reset (synchronous, active low) empties the list and drops any pending result.
// Slot contents are not cleared by reset; only the entry count is.
`default_nettype none
`include "bounded_sorted_list_core_assert.svh"
module bounded_sorted_list_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bsl_cmd_if.sink   i_cmd,
    bsl_res_if.source o_res
);
    localparam logic [bsl_pkg::CNT_W-1:0] FULL_CNT = bsl_pkg::CNT_W'(bsl_pkg::DEPTH);

    logic [bsl_pkg::CNT_W-1:0]        r_count;
    logic [bsl_pkg::CNT_W-1:0]        n_count;
    logic                             r_ovalid;
    logic signed [bsl_pkg::KEY_W-1:0] r_rkey;
    logic [bsl_pkg::CNT_W-1:0]        r_ocnt;
    bsl_pkg::t_status                 r_status;
    bsl_pkg::t_status                 n_status;
    logic signed [bsl_pkg::KEY_W-1:0] n_rkey;

    logic                             accept;
    logic                             full;
    logic                             found;
    bsl_pkg::t_kind                   kind;
    bsl_pkg::t_cmd                    cmd;

    bsl_pkg::t_link                   link   [bsl_pkg::DEPTH+1];
    logic signed [bsl_pkg::KEY_W-1:0] keys   [bsl_pkg::DEPTH];

    assign i_cmd.ready = !r_ovalid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign kind        = bsl_pkg::t_kind'(i_cmd.kind);
    assign full        = (r_count == FULL_CNT);

    always_comb begin
        cmd.kind     = kind;
        cmd.key      = i_cmd.key;
        cmd.position = i_cmd.position;
        cmd.count    = r_count;
        cmd.wr_en    = accept &&
                       !(full && (kind == bsl_pkg::K_APPEND || kind == bsl_pkg::K_INSERT));
    end

    assign link[0] = '{found: 1'b0, rd: '0};

    for (genvar g = 0; g < bsl_pkg::DEPTH; g++) begin : g_cell
        logic signed [bsl_pkg::KEY_W-1:0] left_key;
        logic signed [bsl_pkg::KEY_W-1:0] right_key;

        // end slots: the head never takes from its left, the tail's right is a don't-care
        if (g == 0) begin : g_head
            assign left_key = i_cmd.key;
        end else begin : g_mid
            assign left_key = keys[g-1];
        end
        if (g == bsl_pkg::DEPTH - 1) begin : g_tail
            assign right_key = keys[g];
        end else begin : g_body
            assign right_key = keys[g+1];
        end

        bsl_cell u_cell (
            .i_clk       (i_clk),
            .i_idx       (bsl_pkg::IDX_W'(g)),
            .i_cmd       (cmd),
            .i_left_key  (left_key),
            .i_right_key (right_key),
            .i_link      (link[g]),
            .o_key       (keys[g]),
            .o_link      (link[g+1])
        );
    end

    assign found = link[bsl_pkg::DEPTH].found;

    always_comb begin
        n_count  = r_count;
        n_status = bsl_pkg::ST_OK;
        n_rkey   = '0;
        unique case (kind)
            bsl_pkg::K_APPEND, bsl_pkg::K_INSERT: begin
                if (full) begin
                    n_status = bsl_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            bsl_pkg::K_REMOVE: begin
                if (found) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = bsl_pkg::ST_NOT_FOUND;
                end
            end
            bsl_pkg::K_READ: begin
                if (found) begin
                    n_rkey = link[bsl_pkg::DEPTH].rd;
                end else begin
                    n_status = bsl_pkg::ST_RANGE;
                end
            end
            default: n_status = bsl_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rkey   <= n_rkey;
            r_ocnt   <= n_count;
            r_status <= n_status;
        end
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.read_key    = r_rkey;
    assign o_res.entry_count = r_ocnt;
    assign o_res.status      = r_status;

    `BSL_ASSERT_CLK(a_count_bound, r_count <= FULL_CNT, "entry count beyond depth")
    `BSL_ASSERT_CLK(a_add_grows, (accept && !full && (kind == bsl_pkg::K_APPEND || kind == bsl_pkg::K_INSERT)) |=> (r_count == $past(r_count) + 1'b1), "add did not grow count")
    `BSL_ASSERT_CLK(a_full_status, (r_ovalid && r_status == bsl_pkg::ST_FULL) |-> (r_ocnt == FULL_CNT), "full status with room left")
    `BSL_ASSERT_RST(a_rst_empty, !i_rst_n |=> (r_count == '0 && !r_ovalid), "reset did not empty list")
endmodule
`default_nettype wire

>>> bench/tb.sv
// Self-checking bench for bounded_sorted_list_core: directed plan, then random list traffic
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsl_pkg::*;

    typedef struct packed {
        logic signed [KEY_W-1:0] read_key;
        logic [CNT_W-1:0]        entry_count;
        t_status                 status;
    } list_reply_t;

    typedef struct {
        t_kind                   op;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        pos;
        int                      reps;
        bit                      typed;
        list_reply_t             want;
    } plan_row_t;

    localparam int RANDOM_OPS = 800;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bsl_cmd_if cmd_ch ();
    bsl_res_if res_ch ();

    bounded_sorted_list_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the list, updated as each command beat is accepted
    logic signed [KEY_W-1:0] shadow_keys [DEPTH];
    int                      shadow_count;
    list_reply_t             awaited_replies [$];
    int                      mismatch_count;
    bit                      calm;
    bit                      filling;

    // Directed plan. Typed replies are the ones obvious from the list contents.
    plan_row_t plan [16] = '{
        '{K_READ,   -32'sd1,          4'd0,  1, 1'b1, '{32'sd0, 5'd0, ST_RANGE}},
        '{K_REMOVE, 32'sd5,           4'd0,  1, 1'b1, '{32'sd0, 5'd0, ST_NOT_FOUND}},
        '{K_APPEND, 32'sh7FFF_FFFF,   4'd9,  1, 1'b1, '{32'sd0, 5'd1, ST_OK}},
        '{K_INSERT, 32'sh8000_0000,   4'd15, 1, 1'b1, '{32'sd0, 5'd2, ST_OK}},
        '{K_INSERT, 32'sd0,           4'd0,  1, 1'b0, '{32'sd0, 5'd0, ST_OK}},
        // equal key lands before the existing one
        '{K_INSERT, 32'sd0,           4'd0,  1, 1'b0, '{32'sd0, 5'd0, ST_OK}},
        // append ignores order, so the tail is left unsorted
        '{K_APPEND, -32'sd1,          4'd0,  1, 1'b0, '{32'sd0, 5'd0, ST_OK}},
        '{K_INSERT, 32'sd7,           4'd0,  1, 1'b0, '{32'sd0, 5'd0, ST_OK}},
        '{K_READ,   32'sd0,           4'd0,  1, 1'b1, '{32'sh8000_0000, 5'd6, ST_OK}},
        '{K_READ,   32'sd0,           4'd6,  1, 1'b1, '{32'sd0, 5'd6, ST_RANGE}},
        '{K_REMOVE, 32'sd0,           4'd0,  1, 1'b1, '{32'sd0, 5'd5, ST_OK}},
        '{K_REMOVE, 32'sd12345,       4'd0,  1, 1'b1, '{32'sd0, 5'd5, ST_NOT_FOUND}},
        '{K_APPEND, 32'sh5A5A_5A5A,   4'd3,  11, 1'b0, '{32'sd0, 5'd0, ST_OK}},
        '{K_APPEND, 32'sd3,           4'd0,  1, 1'b1, '{32'sd0, 5'd16, ST_FULL}},
        '{K_INSERT, 32'sh8000_0000,   4'd0,  1, 1'b1, '{32'sd0, 5'd16, ST_FULL}},
        '{K_READ,   32'sd0,           4'd15, 1, 1'b1, '{32'sh5A5A_5A5A, 5'd16, ST_OK}}
    };

    function automatic list_reply_t apply_list_op(input t_kind op,
                                                  input logic signed [KEY_W-1:0] k,
                                                  input logic [POS_W-1:0] pos);
        list_reply_t r;
        int          at;
        int          i;
        r.read_key = '0;
        r.status   = ST_OK;
        case (op)
            K_APPEND, K_INSERT: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    at = shadow_count;
                    if (op == K_INSERT) begin
                        at = 0;
                        while (at < shadow_count && shadow_keys[at] < k) at++;
                    end
                    for (i = shadow_count; i > at; i--) shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[at] = k;
                    shadow_count++;
                end
            end
            K_REMOVE: begin
                at = 0;
                while (at < shadow_count && shadow_keys[at] != k) at++;
                if (at >= shadow_count) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (i = at; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i+1];
                    shadow_count--;
                end
            end
            default: begin
                if (int'(pos) >= shadow_count) r.status = ST_RANGE;
                else r.read_key = shadow_keys[pos];
            end
        endcase
        r.entry_count = CNT_W'(shadow_count);
        return r;
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 15));
    endfunction

    // small pool for duplicates, the extremes, or anything at all
    function automatic logic signed [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return KEY_W'($urandom_range(0, 8)) - KEY_W'(4);
        if (r < 55) begin
            case ($urandom_range(0, 4))
                0: return 32'sh8000_0000;
                1: return 32'sh7FFF_FFFF;
                2: return -32'sd1;
                3: return 32'sd0;
                default: return 32'sd1;
            endcase
        end
        return $urandom();
    endfunction

    task automatic send_op(input t_kind op, input logic signed [KEY_W-1:0] k,
                           input logic [POS_W-1:0] pos, input bit typed,
                           input list_reply_t want);
        int          gap;
        list_reply_t predicted;
        gap = draw_wait();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.kind     <= op;
        cmd_ch.key      <= k;
        cmd_ch.position <= pos;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        predicted = apply_list_op(op, k, pos);
        awaited_replies.push_back(typed ? want : predicted);
    endtask

    // command side
    initial begin
        int                      r;
        t_kind                   op;
        logic signed [KEY_W-1:0] k;
        logic [POS_W-1:0]        pos;
        mismatch_count  = 0;
        shadow_count    = 0;
        calm            = 1'b0;
        filling         = 1'b1;
        i_rst_n         <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.kind     <= K_READ;
        cmd_ch.key      <= '0;
        cmd_ch.position <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[j]) begin
            repeat (plan[j].reps)
                send_op(plan[j].op, plan[j].key, plan[j].pos, plan[j].typed, plan[j].want);
        end

        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            if (shadow_count == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
            if (shadow_count == 0 && $urandom_range(0, 1) == 0) filling = 1'b1;
            if ($urandom_range(0, 99) == 0) filling = ~filling;

            r = $urandom_range(0, 99);
            if (filling)
                op = (r < 30) ? K_APPEND : (r < 75) ? K_INSERT : (r < 85) ? K_REMOVE : K_READ;
            else
                op = (r < 10) ? K_APPEND : (r < 25) ? K_INSERT : (r < 75) ? K_REMOVE : K_READ;

            k = pick_key();
            // removes mostly target a stored key so the list actually drains
            if (op == K_REMOVE && shadow_count > 0 && $urandom_range(0, 3) != 0)
                k = shadow_keys[$urandom_range(0, shadow_count - 1)];

            if (shadow_count > 0 && $urandom_range(0, 9) < 7)
                pos = POS_W'($urandom_range(0, shadow_count - 1));
            else
                pos = POS_W'($urandom_range(0, 15));

            send_op(op, k, pos, 1'b0, '0);
        end

        cmd_ch.valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // result side
    initial begin
        int          stall;
        list_reply_t want;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (res_ch.valid !== 1'b1) @(posedge i_clk);
            if (awaited_replies.size() == 0) begin
                $error("result beat with no command outstanding");
                mismatch_count++;
            end else begin
                want = awaited_replies.pop_front();
                if (res_ch.read_key !== want.read_key) begin
                    $error("read_key: expected %0d, got %0d", want.read_key, res_ch.read_key);
                    mismatch_count++;
                end
                if (res_ch.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, res_ch.entry_count);
                    mismatch_count++;
                end
                if (res_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_ch.status);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
